// ===== rtl/ccpe_pkg.sv =====
// shared constants and helpers for the cubic curve point evaluator
// used by ccpe_div6 and cubic_curve_point_evaluator; no dependencies
package ccpe_pkg;

	localparam int COORD_BITS_DEF  = 24;
	localparam int T_FRAC_BITS_DEF = 16;

	// dividend bits consumed by one divider stage
	localparam int DIV_CHUNK = 8;

	localparam logic BASIS_BEZIER  = 1'b0;
	localparam logic BASIS_BSPLINE = 1'b1;

	// msb-first division by three of one chunk, remainder carried in and out
	// result is {remainder, quotient bits}
	function automatic logic [DIV_CHUNK+1:0] div3_chunk(input logic [1:0] rem_in,
		input logic [DIV_CHUNK-1:0] din);
		logic [1:0]           rem;
		logic [2:0]           part;
		logic [DIV_CHUNK-1:0] quo;
		rem = rem_in;
		quo = '0;
		for (int i = DIV_CHUNK - 1; i >= 0; i--) begin
			part = {rem, din[i]};
			if (part >= 3'd3) begin
				quo[i] = 1'b1;
				rem    = 2'(part - 3'd3);
			end else begin
				quo[i] = 1'b0;
				rem    = part[1:0];
			end
		end
		return {rem, quo};
	endfunction

endpackage

// ===== rtl/ccpe_div6.sv =====
// divide-by-six tail of the evaluator: pipelined msb-first division by three,
// one chunk per stage, then the output register; depends on ccpe_pkg
module ccpe_div6 #(
	parameter int COORD_BITS = ccpe_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS+2:0] in_sum,
	input  logic                  in_spline,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] out_value
);
	import ccpe_pkg::*;

	localparam int RW = COORD_BITS + 3;
	localparam int YW = COORD_BITS + 2;
	localparam int ND = (YW + DIV_CHUNK - 1) / DIV_CHUNK;
	localparam int PW = ND * DIV_CHUNK;

	logic          v_s   [ND];
	logic [1:0]    rem_s [ND];
	logic [PW-1:0] x_s   [ND];
	logic [RW-1:0] r_s   [ND];
	logic          spl_s [ND];
	logic          en    [ND+1];

	logic                  out_v_q;
	logic [COORD_BITS-1:0] out_value_q;

	for (genvar k = 0; k < ND; k++) begin : g_stage
		logic                 vi;
		logic [1:0]           rem_i;
		logic [PW-1:0]        x_i;
		logic [RW-1:0]        r_i;
		logic                 spl_i;
		logic [DIV_CHUNK+1:0] res;
		logic [PW-1:0]        x_next;

		if (k == 0) begin : g_first
			// floor(x/6) = floor(floor(x/2)/3)
			assign vi    = in_valid;
			assign rem_i = 2'd0;
			assign x_i   = PW'(in_sum[RW-1:1]);
			assign r_i   = in_sum;
			assign spl_i = in_spline;
		end else begin : g_next
			assign vi    = v_s[k-1];
			assign rem_i = rem_s[k-1];
			assign x_i   = x_s[k-1];
			assign r_i   = r_s[k-1];
			assign spl_i = spl_s[k-1];
		end

		assign res   = div3_chunk(rem_i, x_i[PW-1-k*DIV_CHUNK -: DIV_CHUNK]);
		assign en[k] = !v_s[k] || en[k+1];

		always_comb begin
			x_next = x_i;
			x_next[PW-1-k*DIV_CHUNK -: DIV_CHUNK] = res[DIV_CHUNK-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k] && vi) begin
				rem_s[k] <= res[DIV_CHUNK+1:DIV_CHUNK];
				x_s[k]   <= x_next;
				r_s[k]   <= r_i;
				spl_s[k] <= spl_i;
			end
		end
	end

	assign en[ND]   = !out_v_q || out_ready;
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en[ND]) begin
			out_v_q <= v_s[ND-1];
		end
	end

	// pick the quotient or the plain sum, then drop the offset by flipping the msb
	always_ff @(posedge clk) begin
		if (en[ND] && v_s[ND-1]) begin
			if (spl_s[ND-1] == BASIS_BSPLINE) begin
				out_value_q <= {~x_s[ND-1][COORD_BITS-1], x_s[ND-1][COORD_BITS-2:0]};
			end else begin
				out_value_q <= {~r_s[ND-1][COORD_BITS-1], r_s[ND-1][COORD_BITS-2:0]};
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_value = out_value_q;

endmodule

// ===== rtl/cubic_curve_point_evaluator.sv =====
// cubic curve point evaluator: bezier / uniform b-spline blend of four
// coordinates at parameter t; depends on ccpe_pkg and ccpe_div6
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one item: t and four control coordinates.
//   m_tvalid/m_tready/m_tdata carry the blended coordinate, one per item.
//   cfg_valid/cfg_ready/cfg_data write basis_select (0 bezier, 1 b-spline);
//   cfg_ready is always high, write only while no item is in flight.
// stages: 8 arithmetic stages, ceil((COORD_BITS+2)/8) divide-by-three stages
//   and one output register.
// throughput: one item per clock unless stalled. every stage holds one item
//   in registers, weight products as two half-width multiplies per point.
// each stage has its own valid bit and moves when the next one is empty or
//   moving, so bubbles close up and a waiting result does not block input
//   until the pipeline is full.
// stall: when m_tready stays low, items pile up stage by stage and s_tready
//   drops once every stage holds one; nothing is lost or repeated.
// reset: arst_n clears all valid bits and sets basis_select to bezier.
module cubic_curve_point_evaluator #(
	parameter int COORD_BITS  = ccpe_pkg::COORD_BITS_DEF,
	parameter int T_FRAC_BITS = ccpe_pkg::T_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// param_t, ctrl_0, ctrl_1, ctrl_2, ctrl_3 (low to high), zero padded
	input  logic [((T_FRAC_BITS+1+4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// curve_value, zero padded
	output logic [((COORD_BITS+7)/8)*8-1:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	import ccpe_pkg::*;

	localparam int F   = T_FRAC_BITS;
	localparam int CB  = COORD_BITS;
	localparam int TW  = F + 1;
	localparam int T2W = 2 * F + 1;
	localparam int T3W = 3 * F + 1;
	localparam int WB  = 3 * F + 3;
	localparam int HL  = (WB + 1) / 2;
	localparam int HH  = WB - HL;
	localparam int AW  = WB + CB;
	localparam int RW  = CB + 3;
	localparam int OW  = ((CB + 7) / 8) * 8;

	localparam logic [TW-1:0] T_ONE  = TW'(1) << F;
	localparam logic [WB-1:0] S3     = WB'(1) << (3 * F);

	logic basis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_q <= BASIS_BEZIER;
		end else if (cfg_valid) begin
			basis_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	// stage enables: a stage loads when it is empty or its contents move on
	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic div_ready;

	assign en8 = !v_s8 || div_ready;
	assign en7 = !v_s7 || en8;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	// stage 1: clamp t, form u = 1 - t, offset coordinates to unsigned
	logic [TW-1:0] t_raw, t_in;
	logic [CB-1:0] q_in [4];

	assign t_raw = s_tdata[TW-1:0];
	assign t_in  = (t_raw > T_ONE) ? T_ONE : t_raw;

	for (genvar i = 0; i < 4; i++) begin : g_unpack
		assign q_in[i] = {~s_tdata[TW+i*CB+CB-1], s_tdata[TW+i*CB +: CB-1]};
	end

	logic [TW-1:0] t_s1, u_s1;
	logic [CB-1:0] q_s1 [4];
	logic          spl_s1;

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			t_s1   <= t_in;
			u_s1   <= T_ONE - t_in;
			q_s1   <= q_in;
			spl_s1 <= basis_q;
		end
	end

	// stage 2: squares
	logic [2*TW-1:0] tt_full, uu_full;
	assign tt_full = (2*TW)'(t_s1) * (2*TW)'(t_s1);
	assign uu_full = (2*TW)'(u_s1) * (2*TW)'(u_s1);

	logic [T2W-1:0] tt_s2, uu_s2;
	logic [TW-1:0]  t_s2, u_s2;
	logic [CB-1:0]  q_s2 [4];
	logic           spl_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			tt_s2  <= tt_full[T2W-1:0];
			uu_s2  <= uu_full[T2W-1:0];
			t_s2   <= t_s1;
			u_s2   <= u_s1;
			q_s2   <= q_s1;
			spl_s2 <= spl_s1;
		end
	end

	// stage 3: cubes and mixed cubic terms
	logic [T2W+TW-1:0] ttt_full, uuu_full, utt_full, uut_full;
	assign ttt_full = (T2W+TW)'(tt_s2) * (T2W+TW)'(t_s2);
	assign uuu_full = (T2W+TW)'(uu_s2) * (T2W+TW)'(u_s2);
	assign utt_full = (T2W+TW)'(tt_s2) * (T2W+TW)'(u_s2);
	assign uut_full = (T2W+TW)'(uu_s2) * (T2W+TW)'(t_s2);

	logic [T3W-1:0] ttt_s3, uuu_s3, utt_s3, uut_s3;
	logic [T2W-1:0] tt_s3;
	logic [TW-1:0]  t_s3;
	logic [CB-1:0]  q_s3 [4];
	logic           spl_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			ttt_s3 <= ttt_full[T3W-1:0];
			uuu_s3 <= uuu_full[T3W-1:0];
			utt_s3 <= utt_full[T3W-1:0];
			uut_s3 <= uut_full[T3W-1:0];
			tt_s3  <= tt_s2;
			t_s3   <= t_s2;
			q_s3   <= q_s2;
			spl_s3 <= spl_s2;
		end
	end

	// stage 4: basis weights scaled by S^3 (bezier) or 6*S^3 (b-spline)
	// all weights are non-negative and fit WB bits, so wrapping sums are exact
	logic [WB-1:0] ttt_w, uuu_w, utt_w, uut_w, tts_w, tss_w;
	logic [WB-1:0] w_next [4];
	logic [WB-1:0] cst_next;

	assign ttt_w = WB'(ttt_s3);
	assign uuu_w = WB'(uuu_s3);
	assign utt_w = WB'(utt_s3);
	assign uut_w = WB'(uut_s3);
	assign tts_w = WB'(tt_s3) << F;
	assign tss_w = WB'(t_s3) << (2 * F);

	always_comb begin
		w_next[0] = uuu_w;
		w_next[3] = ttt_w;
		if (spl_s3 == BASIS_BSPLINE) begin
			w_next[1] = (ttt_w << 1) + ttt_w + (S3 << 2) - (tts_w << 2) - (tts_w << 1);
			w_next[2] = (tts_w << 1) + tts_w + (tss_w << 1) + tss_w + S3
				- (ttt_w << 1) - ttt_w;
			cst_next  = (S3 << 1) + S3;
		end else begin
			w_next[1] = (uut_w << 1) + uut_w;
			w_next[2] = (utt_w << 1) + utt_w;
			cst_next  = S3 >> 1;
		end
	end

	logic [WB-1:0] w_s4 [4];
	logic [WB-1:0] cst_s4;
	logic [CB-1:0] q_s4 [4];
	logic          spl_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			w_s4   <= w_next;
			cst_s4 <= cst_next;
			q_s4   <= q_s3;
			spl_s4 <= spl_s3;
		end
	end

	// stage 5: each weight times its coordinate as two half-width products
	logic [HL+CB-1:0] plo_s5 [4];
	logic [HH+CB-1:0] phi_s5 [4];
	logic [WB-1:0]    cst_s5;
	logic             spl_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			for (int i = 0; i < 4; i++) begin
				plo_s5[i] <= (HL+CB)'(w_s4[i][HL-1:0]) * (HL+CB)'(q_s4[i]);
				phi_s5[i] <= (HH+CB)'(w_s4[i][WB-1:HL]) * (HH+CB)'(q_s4[i]);
			end
			cst_s5 <= cst_s4;
			spl_s5 <= spl_s4;
		end
	end

	// stage 6: recombine the halves
	logic [AW-1:0] p_s6 [4];
	logic [WB-1:0] cst_s6;
	logic          spl_s6;

	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			for (int i = 0; i < 4; i++) begin
				p_s6[i] <= (AW'(phi_s5[i]) << HL) + AW'(plo_s5[i]);
			end
			cst_s6 <= cst_s5;
			spl_s6 <= spl_s5;
		end
	end

	// stage 7: two partial sums, rounding constant folded into the second
	logic [AW-1:0] sa_s7, sb_s7;
	logic          spl_s7;

	always_ff @(posedge clk) begin
		if (en7 && v_s6) begin
			sa_s7  <= p_s6[0] + p_s6[1];
			sb_s7  <= p_s6[2] + p_s6[3] + AW'(cst_s6);
			spl_s7 <= spl_s6;
		end
	end

	// stage 8: total, scaled down by S^3
	logic [AW-1:0] tot;
	assign tot = sa_s7 + sb_s7;

	logic [RW-1:0] r_s8;
	logic          spl_s8;

	always_ff @(posedge clk) begin
		if (en8 && v_s7) begin
			r_s8   <= tot[AW-1:3*F];
			spl_s8 <= spl_s7;
		end
	end

	logic [CB-1:0] curve_value;

	ccpe_div6 #(
		.COORD_BITS(CB)
	) u_div6 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s8),
		.in_ready  (div_ready),
		.in_sum    (r_s8),
		.in_spline (spl_s8),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (curve_value)
	);

	assign m_tdata = OW'(curve_value);

	// weights of either basis always add up to the full scale
	logic [WB+1:0] wsum_chk, wsum_exp;
	assign wsum_chk = (WB+2)'(w_s4[0]) + (WB+2)'(w_s4[1]) + (WB+2)'(w_s4[2])
		+ (WB+2)'(w_s4[3]);
	assign wsum_exp = (spl_s4 == BASIS_BSPLINE) ? ((WB+2)'(S3) << 2) + ((WB+2)'(S3) << 1)
		: (WB+2)'(S3);

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> wsum_chk == wsum_exp)
		else $error("basis weights do not sum to full scale");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> ((spl_s8 == BASIS_BSPLINE) ? (r_s8 < (RW'(6) << CB))
		: (r_s8 < (RW'(1) << CB))))
		else $error("scaled sum outside the control point range");

	a_stage8_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !div_ready |=> v_s8 && $stable(r_s8) && $stable(spl_s8))
		else $error("stalled item changed before the divider took it");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input held off while the output register is empty");

endmodule

// ===== tb/cubic_curve_point_evaluator_test.sv =====
// self-checking bench for cubic_curve_point_evaluator: a directed table, then random items
// in both bases, checked against the table or a bit-exact blend model; needs ccpe_pkg and rtl
module cubic_curve_point_evaluator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ccpe_pkg::*;

	localparam logic [23:0] C_MIN     = 24'h800000;
	localparam logic [23:0] C_MAX     = 24'h7FFFFF;
	localparam logic [16:0] T_ONE     = 17'h10000;
	localparam logic [16:0] T_RAW_MAX = 17'h1FFFF;
	localparam int RANDOM_PHASES   = 4;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int HOLD_OFF_AT     = 300;
	localparam int HOLD_OFF_CYCLES = 120;
	localparam int TAIL_CYCLES     = 30;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int N_DIRECTED      = 22;

	typedef struct packed {
		logic        basis;
		logic [16:0] t;
		logic [23:0] c0;
		logic [23:0] c1;
		logic [23:0] c2;
		logic [23:0] c3;
		logic        known;
		logic [23:0] want;
	} curve_case_t;

	// basis, t, c0..c3, result known up front, that result
	curve_case_t directed_cases [0:N_DIRECTED-1] = '{
		'{BASIS_BEZIER,  17'h00000, C_MAX, 24'h0, 24'h0, 24'h0, 1'b1, C_MAX},
		'{BASIS_BEZIER,  17'h00000, C_MIN, C_MAX, C_MAX, C_MAX, 1'b1, C_MIN},
		'{BASIS_BEZIER,  T_ONE, C_MAX, C_MIN, 24'h00007B, C_MIN, 1'b1, C_MIN},
		'{BASIS_BEZIER,  T_ONE, 24'h0, 24'h0, 24'h0, C_MAX, 1'b1, C_MAX},
		// t above one clamps to the last control point
		'{BASIS_BEZIER,  T_RAW_MAX, 24'h1, 24'h2, 24'h3, 24'h000456, 1'b1, 24'h000456},
		'{BASIS_BEZIER,  17'h10001, C_MAX, C_MIN, C_MAX, 24'hFFFF00, 1'b1, 24'hFFFF00},
		// halfway ties round up: -0.5 lsb gives 0, +0.5 lsb gives 1
		'{BASIS_BEZIER,  17'h08000, 24'hFFFFFC, 24'h0, 24'h0, 24'h0, 1'b1, 24'h000000},
		'{BASIS_BEZIER,  17'h08000, 24'h000004, 24'h0, 24'h0, 24'h0, 1'b1, 24'h000001},
		'{BASIS_BEZIER,  17'h03039, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, C_MAX},
		'{BASIS_BEZIER,  17'h0D431, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, C_MIN},
		'{BASIS_BEZIER,  17'h00001, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0, 24'h0},
		'{BASIS_BEZIER,  17'h0FFFF, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 24'h0},
		'{BASIS_BEZIER,  17'h05555, 24'h123456, 24'hEDCBA9, 24'h000100, 24'hFFFF00,
			1'b0, 24'h0},
		'{BASIS_BSPLINE, 17'h00000, 24'h000003, 24'h0, 24'h0, 24'h0, 1'b1, 24'h000001},
		'{BASIS_BSPLINE, 17'h00000, 24'hFFFFFD, 24'h0, 24'h0, 24'h0, 1'b1, 24'h000000},
		'{BASIS_BSPLINE, 17'h00000, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, C_MAX},
		'{BASIS_BSPLINE, T_ONE, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1, C_MIN},
		'{BASIS_BSPLINE, T_RAW_MAX, 24'h000ABC, 24'h000ABC, 24'h000ABC, 24'h000ABC,
			1'b1, 24'h000ABC},
		'{BASIS_BSPLINE, T_ONE, C_MAX, C_MIN, C_MAX, C_MIN, 1'b0, 24'h0},
		'{BASIS_BSPLINE, 17'h00000, C_MIN, C_MAX, C_MIN, C_MAX, 1'b0, 24'h0},
		'{BASIS_BSPLINE, 17'h08000, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0, 24'h0},
		'{BASIS_BSPLINE, 17'h10001, 24'h000600, 24'h0, 24'h0, 24'hFFFA00, 1'b0, 24'h0}
	};

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// param_t, ctrl_0, ctrl_1, ctrl_2, ctrl_3 (low to high), zero padded
	logic [119:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// curve_value
	logic [23:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic         cfg_data;

	logic         basis_now;
	logic [23:0]  pending_coords [$];
	logic [23:0]  head_coord;
	int           errors;
	int           items_sent;
	int           quiet_cycles = 0;
	int           send_burst;
	int           recv_burst;
	bit           held_off;

	cubic_curve_point_evaluator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// exact weighted sum in offset-binary, one rounding at the end
	function automatic logic [23:0] blend_coord(input logic sel, input logic [16:0] t_raw,
		input logic [23:0] c0, input logic [23:0] c1, input logic [23:0] c2,
		input logic [23:0] c3);
		logic [127:0] s, t, u, q0, q1, q2, q3, w0, w1, w2, w3, acc, r;
		s  = 128'd65536;
		t  = (t_raw > 17'h10000) ? s : {111'd0, t_raw};
		u  = s - t;
		q0 = {104'd0, c0 ^ 24'h800000};
		q1 = {104'd0, c1 ^ 24'h800000};
		q2 = {104'd0, c2 ^ 24'h800000};
		q3 = {104'd0, c3 ^ 24'h800000};
		w0 = u * u * u;
		w3 = t * t * t;
		if (sel == BASIS_BEZIER) begin
			w1  = 3 * u * u * t;
			w2  = 3 * u * t * t;
			acc = w0 * q0 + w1 * q1 + w2 * q2 + w3 * q3 + ((s * s * s) >> 1);
			r   = acc >> 48;
		end else begin
			w1  = 3 * t * t * t + 4 * s * s * s - 6 * t * t * s;
			w2  = 3 * t * t * s + 3 * t * s * s + s * s * s - 3 * t * t * t;
			acc = w0 * q0 + w1 * q1 + w2 * q2 + w3 * q3 + 3 * s * s * s;
			r   = (acc >> 48) / 6;
		end
		return r[23:0] ^ 24'h800000;
	endfunction

	// mostly back to back or short gaps, now and then a long one or a burst
	function automatic int idle_len(inout int burst_left);
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [16:0] pick_t();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			case ($urandom_range(0, 3))
				0: return 17'h00000;
				1: return T_ONE;
				2: return 17'h00001;
				default: return 17'h0FFFF;
			endcase
		end
		if (r < 14)
			return 17'($urandom_range(65537, 131071));
		return 17'($urandom_range(0, 65536));
	endfunction

	// mode 0 any value, 1 an extreme, 2 near the base point like a real curve
	function automatic logic [23:0] pick_coord(input logic [23:0] base, input int mode);
		logic [23:0] off;
		off = 24'($urandom_range(0, 4095)) - 24'd2048;
		case (mode)
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? C_MAX : C_MIN;
			default: return base + off;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
		input logic [23:0] want);
		$display("mismatch: %s, got %h want %h", what, got, want);
		errors++;
	endtask

	task automatic send_point(input logic [16:0] t, input logic [23:0] c0,
		input logic [23:0] c1, input logic [23:0] c2, input logic [23:0] c3,
		input logic known, input logic [23:0] want);
		int gap;
		gap = idle_len(send_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, c3, c2, c1, c0, t};
		do @(posedge clk); while (!s_tready);
		pending_coords.push_back(known ? want : blend_coord(basis_now, t, c0, c1, c2, c3));
		items_sent++;
	endtask

	task automatic wait_drained();
		while (pending_coords.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_basis(input logic sel);
		s_tvalid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= sel;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		basis_now = sel;
	endtask

	initial begin : stimulus
		logic [23:0] base;
		int          mode;
		curve_case_t row;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= 1'b0;
		basis_now  = BASIS_BEZIER;
		errors     = 0;
		items_sent = 0;
		send_burst = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		set_basis(BASIS_BEZIER);

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_cases[i];
			if (row.basis != basis_now)
				set_basis(row.basis);
			send_point(row.t, row.c0, row.c1, row.c2, row.c3, row.known, row.want);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_basis(ph[0] ? BASIS_BSPLINE : BASIS_BEZIER);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				base = 24'($urandom);
				mode = $urandom_range(0, 99);
				if (mode < 45)
					send_point(pick_t(), pick_coord(base, 0), pick_coord(base, 0),
						pick_coord(base, 0), pick_coord(base, 0), 1'b0, '0);
				else if (mode < 60)
					send_point(pick_t(), pick_coord(base, $urandom_range(0, 1)),
						pick_coord(base, $urandom_range(0, 1)),
						pick_coord(base, $urandom_range(0, 1)),
						pick_coord(base, $urandom_range(0, 1)), 1'b0, '0);
				else
					send_point(pick_t(), base, pick_coord(base, 2), pick_coord(base, 2),
						pick_coord(base, 2), 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("cubic_curve_point_evaluator_test: done, clean");
		else
			$display("cubic_curve_point_evaluator_test: done, errors");
		$finish;
	end

	// output side: random back-pressure, plus one long hold-off to fill the pipe
	initial begin : receiver
		int gap;
		m_tready   <= 1'b0;
		recv_burst = 0;
		held_off   = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held_off && items_sent >= HOLD_OFF_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end else begin
				gap = idle_len(recv_burst);
				if (gap == 0) begin
					m_tready <= 1'b1;
					@(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
					m_tready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_coords.size() == 0) begin
				report_mismatch("curve_value with no item pending", m_tdata, '0);
			end else begin
				head_coord = pending_coords.pop_front();
				if (m_tdata !== head_coord)
					report_mismatch("curve_value", m_tdata, head_coord);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("cubic_curve_point_evaluator_test: done, errors");
			$finish;
		end
	end

endmodule
